### src/cist_pkg.sv
// Package for the closed interval set table: opcodes, status codes, FSM state type.
// No dependencies.
package cist_pkg;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam int FIELD_BITS = 32;
  typedef logic [3:0] fsm_t;
endpackage

### src/cist_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module cist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/closed_interval_set_table.sv
// Closed interval set table top level: APB register, sequencer, start/end RAMs.
// Depends on cist_pkg and cist_ram.
//
// Usage: an item (op, first_value, second_value) is a transfer on in_valid with
// in_stall low. in_stall stays high while an item is in work and while its
// result waits. One result per item appears on out_valid and holds until a
// cycle with out_stall low; the next item is taken in the cycle after that.
// Insert, remove and lookup scan the table one entry per cycle through the
// single read port of each RAM and a shared compare unit; insert and remove
// then compact or open up the table, moving one entry at a time (read, write).
// A lookup takes longer the more intervals are stored; insert and remove take
// longer still, and also grow with each entry moved behind the changed range.
// Reset empties the table and clears merge_adjacent; RAM contents are not
// cleared, since entries at or above the count are never used.
// merge_adjacent is at APB byte address 0.
module closed_interval_set_table #(
  parameter int MAX_INTERVALS = 64,
  parameter int COORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic signed [31:0] in_first_value,
  input  logic signed [31:0] in_second_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic signed [31:0] out_seg_start,
  output logic signed [31:0] out_seg_end,
  output logic        out_same_segment,
  output logic [6:0]  out_interval_count
);
  import cist_pkg::*;
  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int IW = CW + 1;
  localparam logic [COORD_BITS-1:0] CMAX = {COORD_BITS{1'b1}};
  localparam logic [COORD_BITS-1:0] CSIGN = {1'b1, {(COORD_BITS-1){1'b0}}};

  localparam fsm_t S_IDLE = 4'd0;
  localparam fsm_t S_SCAN = 4'd1;
  localparam fsm_t S_SCANW = 4'd2;
  localparam fsm_t S_RDA = 4'd3;
  localparam fsm_t S_RDAW = 4'd4;
  localparam fsm_t S_RDB = 4'd5;
  localparam fsm_t S_RDBW = 4'd6;
  localparam fsm_t S_PLAN = 4'd7;
  localparam fsm_t S_MVR = 4'd8;
  localparam fsm_t S_MVW = 4'd9;
  localparam fsm_t S_WR0 = 4'd10;
  localparam fsm_t S_WR1 = 4'd11;
  localparam fsm_t S_DONE = 4'd12;
  localparam fsm_t S_SCAN2 = 4'd13;
  localparam fsm_t S_SCAN2W = 4'd14;

  fsm_t st_r, st_nxt;
  logic merge_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0] op_r, op_nxt;
  logic [COORD_BITS-1:0] x_r, x_nxt, y_r, y_nxt, lt_r, lt_nxt, rr_r, rr_nxt;
  logic [IW-1:0] idx_r, idx_nxt, a_r, a_nxt, b_r, b_nxt, k_r, k_nxt;
  logic [IW-1:0] mi_r, mi_nxt, me_r, me_nxt;
  logic [COORD_BITS-1:0] sa_r, sa_nxt;
  logic [COORD_BITS-1:0] p0s_r, p0s_nxt, p0e_r, p0e_nxt, p1s_r, p1s_nxt, p1e_r, p1e_nxt;
  logic ovalid_r, ovalid_nxt;
  logic [1:0] ostat_r, ostat_nxt;
  logic ofound_r, ofound_nxt, osame_r, osame_nxt;
  logic [31:0] oss_r, oss_nxt, ose_r, ose_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [COORD_BITS-1:0] ws, wend, rs, re;

  cist_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_INTERVALS)) u_starts (
    .clk(clk), .we(we), .waddr(waddr), .wdata(ws), .raddr(raddr), .rdata(rs));
  cist_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_INTERVALS)) u_ends (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wend), .raddr(raddr), .rdata(re));

  function automatic logic [COORD_BITS-1:0] to_key(input logic [31:0] f);
    logic [63:0] v;
    v = {{32{f[31]}}, f};
    return v[COORD_BITS-1:0] ^ CSIGN;
  endfunction
  function automatic logic [31:0] from_key(input logic [COORD_BITS-1:0] k);
    logic [63:0] v;
    v = 64'(k ^ CSIGN);
    return v[31:0];
  endfunction

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, merge_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      merge_r <= cfg_pwdata[0];
    end
  end

  // shared compare unit: scan key against stored start
  logic [COORD_BITS-1:0] skey;
  logic sle;
  assign sle = rs <= skey;

  logic [IW-1:0] cnt_x;
  assign cnt_x = IW'(cnt_r);
  logic [IW-1:0] newcnt;
  assign newcnt = cnt_x - (b_r - a_r) + k_r;
  logic [IW-1:0] tail;
  assign tail = cnt_x - b_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; op_nxt = op_r; x_nxt = x_r; y_nxt = y_r;
    lt_nxt = lt_r; rr_nxt = rr_r; idx_nxt = idx_r; a_nxt = a_r; b_nxt = b_r;
    k_nxt = k_r; mi_nxt = mi_r; me_nxt = me_r; sa_nxt = sa_r;
    p0s_nxt = p0s_r; p0e_nxt = p0e_r; p1s_nxt = p1s_r; p1e_nxt = p1e_r;
    ovalid_nxt = ovalid_r; ostat_nxt = ostat_r; ofound_nxt = ofound_r;
    osame_nxt = osame_r; oss_nxt = oss_r; ose_nxt = ose_r;
    we = 1'b0; waddr = '0; ws = '0; wend = '0;
    raddr = idx_r[AW-1:0];
    skey = (st_r == S_SCAN2 || st_r == S_SCAN2W) ? rr_r : x_r;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          op_nxt = in_op;
          x_nxt = to_key(in_first_value);
          y_nxt = to_key(in_second_value);
          idx_nxt = '0;
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if ((op_r == OP_INSERT || op_r == OP_REMOVE) && x_r > y_r) begin
          ostat_nxt = ST_ORDER; ofound_nxt = 1'b0; osame_nxt = 1'b0;
          oss_nxt = '0; ose_nxt = '0; st_nxt = S_DONE;
        end else if (op_r != OP_INSERT && op_r != OP_REMOVE && op_r != OP_LOOKUP) begin
          ostat_nxt = ST_OK; ofound_nxt = 1'b0; osame_nxt = 1'b0;
          oss_nxt = '0; ose_nxt = '0; st_nxt = S_DONE;
        end else begin
          if (op_r == OP_INSERT) begin
            rr_nxt = (merge_r && y_r != CMAX) ? y_r + 1'b1 : y_r;
            lt_nxt = (merge_r && x_r != '0) ? x_r - 1'b1 : x_r;
          end else begin
            rr_nxt = y_r; lt_nxt = x_r;
          end
          if (idx_r >= cnt_x) begin
            a_nxt = idx_r; st_nxt = S_SCAN2;
          end else st_nxt = S_SCANW;
        end
      end
      S_SCANW: begin
        if (sle) begin
          idx_nxt = idx_r + 1'b1;
          st_nxt = (idx_r + 1'b1 >= cnt_x) ? S_SCAN2 : S_SCANW;
          if (idx_r + 1'b1 >= cnt_x) a_nxt = idx_r + 1'b1;
          else raddr = AW'(idx_r + 1'b1);
        end else begin
          a_nxt = idx_r; st_nxt = S_SCAN2;
        end
      end
      S_SCAN2: begin
        if (idx_r >= cnt_x) begin
          b_nxt = idx_r; st_nxt = S_RDA;
        end else st_nxt = S_SCAN2W;
      end
      S_SCAN2W: begin
        if (sle) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 >= cnt_x) begin
            b_nxt = idx_r + 1'b1; st_nxt = S_RDA;
          end else raddr = AW'(idx_r + 1'b1);
        end else begin
          b_nxt = idx_r; st_nxt = S_RDA;
        end
      end
      S_RDA: begin
        raddr = AW'(a_r - 1'b1);
        st_nxt = S_RDAW;
      end
      S_RDAW: begin
        sa_nxt = rs;
        if (op_r == OP_LOOKUP) begin
          ostat_nxt = ST_OK;
          if (a_r != '0 && re >= x_r) begin
            ofound_nxt = 1'b1; oss_nxt = from_key(rs); ose_nxt = from_key(re);
            osame_nxt = rs <= y_r && y_r <= re;
          end else begin
            ofound_nxt = 1'b0; oss_nxt = '0; ose_nxt = '0; osame_nxt = 1'b0;
          end
          st_nxt = S_DONE;
        end else begin
          if (a_r != '0 && re >= lt_r) a_nxt = a_r - 1'b1;
          st_nxt = S_RDB;
        end
      end
      S_RDB: begin
        raddr = AW'(a_r);
        st_nxt = S_RDBW;
      end
      S_RDBW: begin
        sa_nxt = rs;
        raddr = AW'(b_r - 1'b1);
        st_nxt = S_PLAN;
      end
      S_PLAN: begin
        ofound_nxt = 1'b0; osame_nxt = 1'b0; oss_nxt = '0; ose_nxt = '0;
        if (op_r == OP_INSERT) begin
          k_nxt = IW'(1);
          p0s_nxt = (a_r < b_r && sa_r < x_r) ? sa_r : x_r;
          p0e_nxt = (a_r < b_r && re > y_r) ? re : y_r;
          st_nxt = S_WR0;
        end else if (a_r >= b_r) begin
          ostat_nxt = ST_OK; st_nxt = S_DONE;
        end else begin
          if (sa_r < x_r && y_r < re) begin
            k_nxt = IW'(2);
            p0s_nxt = sa_r; p0e_nxt = x_r - 1'b1; p1s_nxt = y_r + 1'b1; p1e_nxt = re;
          end else if (sa_r < x_r) begin
            k_nxt = IW'(1); p0s_nxt = sa_r; p0e_nxt = x_r - 1'b1;
          end else if (y_r < re) begin
            k_nxt = IW'(1); p0s_nxt = y_r + 1'b1; p0e_nxt = re;
          end else k_nxt = '0;
          st_nxt = S_WR0;
        end
      end
      S_WR0: begin
        // capacity check, then set up the move of the tail
        if (newcnt > IW'(MAX_INTERVALS)) begin
          ostat_nxt = ST_FULL; st_nxt = S_DONE;
        end else begin
          ostat_nxt = ST_OK;
          if (a_r + k_r > b_r) begin
            mi_nxt = tail; me_nxt = '0; // move downward from the end
          end else begin
            mi_nxt = '0; me_nxt = tail;
          end
          st_nxt = S_MVR;
        end
      end
      S_MVR: begin
        if (a_r + k_r > b_r) begin
          if (mi_r == '0) st_nxt = S_WR1;
          else begin
            raddr = AW'(b_r + mi_r - 1'b1); st_nxt = S_MVW;
          end
        end else begin
          if (mi_r >= me_r) st_nxt = S_WR1;
          else begin
            raddr = AW'(b_r + mi_r); st_nxt = S_MVW;
          end
        end
      end
      S_MVW: begin
        we = 1'b1; ws = rs; wend = re;
        if (a_r + k_r > b_r) begin
          waddr = AW'(a_r + k_r + mi_r - 1'b1); mi_nxt = mi_r - 1'b1;
        end else begin
          waddr = AW'(a_r + k_r + mi_r); mi_nxt = mi_r + 1'b1;
        end
        st_nxt = S_MVR;
      end
      S_WR1: begin
        if (k_r != '0) begin
          we = 1'b1; waddr = AW'(a_r); ws = p0s_r; wend = p0e_r;
        end
        if (k_r == IW'(2)) begin
          // second piece next cycle; a+1 with k-1 keeps the new count unchanged
          k_nxt = IW'(1); a_nxt = a_r + 1'b1; p0s_nxt = p1s_r; p0e_nxt = p1e_r;
        end else begin
          cnt_nxt = CW'(newcnt);
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (st_r != S_IDLE) || ovalid_r;
  assign out_valid = ovalid_r;
  assign out_status = ostat_r;
  assign out_found = ofound_r;
  assign out_seg_start = oss_r;
  assign out_seg_end = ose_r;
  assign out_same_segment = osame_r;
  assign out_interval_count = 7'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ovalid_r <= ovalid_nxt;
    end
    op_r <= op_nxt; x_r <= x_nxt; y_r <= y_nxt; lt_r <= lt_nxt; rr_r <= rr_nxt;
    idx_r <= idx_nxt; a_r <= a_nxt; b_r <= b_nxt; k_r <= k_nxt; mi_r <= mi_nxt;
    me_r <= me_nxt; sa_r <= sa_nxt;
    p0s_r <= p0s_nxt; p0e_r <= p0e_nxt; p1s_r <= p1s_nxt; p1e_r <= p1e_nxt;
    ostat_r <= ostat_nxt; ofound_r <= ofound_nxt; osame_r <= osame_nxt;
    oss_r <= oss_nxt; ose_r <= ose_nxt;
  end
endmodule

### src/cist_checker.sv
// Port-level checker for closed_interval_set_table, bound to the top level.
// Depends on cist_pkg.
module cist_checker #(
  parameter int MAX_INTERVALS = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_found,
  input logic        out_same_segment,
  input logic [6:0]  out_interval_count
);
  import cist_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)) else $error("out held");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("not busy after transfer");
  a_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_same_segment |-> out_found) else $error("same without found");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK) else $error("found with error");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_interval_count <= 7'(MAX_INTERVALS)) else $error("count overflow");
endmodule

bind closed_interval_set_table cist_checker #(.MAX_INTERVALS(MAX_INTERVALS)) u_cist_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_found(out_found), .out_same_segment(out_same_segment),
  .out_interval_count(out_interval_count));
